@@ src/drvd_pkg.sv @@
// Shared types and constants for the data-identifier response value decoder.
package drvd_pkg;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_CFG    = 3'd1,
        ST_UNMAPPED   = 3'd2,
        ST_SHORT      = 3'd3,
        ST_UNEXPECTED = 3'd4
    } status_t;

    // register indexes, byte address = 8 * index
    localparam logic [2:0] REG_MAPPED       = 3'd0;
    localparam logic [2:0] REG_DID_VALUE    = 3'd1;
    localparam logic [2:0] REG_VALUE_BYTES  = 3'd2;
    localparam logic [2:0] REG_ENCODING     = 3'd3;
    localparam logic [2:0] REG_SCALE_FACTOR = 3'd4;
    localparam logic [2:0] REG_VALUE_OFFSET = 3'd5;

    localparam logic [7:0] RESP_CODE = 8'h62;
    localparam logic [2:0] HDR_LEN   = 3'd3;
    localparam logic [2:0] CNT_MAX   = 3'd7;

    localparam logic [63:0] SAT_POS = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

endpackage

@@ src/did_response_value_decoder_top.sv @@
// Data-identifier response decoder: byte stream in, scaled value and status out.
//
// Response bytes arrive on the s_axis channel one word per cycle, tlast on the
// final byte of a message. Every byte is taken as soon as it is offered while
// the result pipe has room; only the byte carrying tlast produces a word on
// m_axis: {scaled_value, status}. Byte 0 must be 0x62 and bytes 1..2 the
// configured identifier, high byte first; value bytes follow from byte 3.
// m_axis_tvalid rises once the result has passed the check/sign stage, which loads
// on the edge that takes the last byte, then the multiply stage, then the offset
// add with saturation stage.
// Throughput: one byte per cycle while m_axis_tready keeps the pipe moving, set by
// the three result stages each moving on when the stage behind it is free.
// A stall on m_axis_tready holds the output word; the stages behind it fill,
// and s_axis_tready drops only when all three hold a result.
// Reset clears the configuration registers, the message state and all valid
// flags. Configuration is written over the APB port (8-byte register stride);
// the user writes it only while no message is in flight, which the block does not enforce.
module did_response_value_decoder_top #(
    parameter int MAX_VALUE_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pdu_byte
    input  logic        s_axis_tlast,   // last_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // [2:0] status, [66:3] scaled_value, [71:67] zero
);

    localparam int ACC_W = 8 * MAX_VALUE_BYTES;

    // ---------------- configuration ----------------
    logic               mapped_reg;
    logic [15:0]        did_value_reg;
    logic [2:0]         value_bytes_reg;
    logic [1:0]         encoding_reg;
    logic signed [31:0] scale_factor_reg;
    logic signed [47:0] value_offset_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapped_reg       <= 1'b0;
            did_value_reg    <= '0;
            value_bytes_reg  <= '0;
            encoding_reg     <= '0;
            scale_factor_reg <= '0;
            value_offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                drvd_pkg::REG_MAPPED:       mapped_reg       <= pwdata[0];
                drvd_pkg::REG_DID_VALUE:    did_value_reg    <= pwdata[15:0];
                drvd_pkg::REG_VALUE_BYTES:  value_bytes_reg  <= pwdata[2:0];
                drvd_pkg::REG_ENCODING:     encoding_reg     <= pwdata[1:0];
                drvd_pkg::REG_SCALE_FACTOR: scale_factor_reg <= pwdata[31:0];
                drvd_pkg::REG_VALUE_OFFSET: value_offset_reg <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            drvd_pkg::REG_MAPPED:       prdata = {63'd0, mapped_reg};
            drvd_pkg::REG_DID_VALUE:    prdata = {48'd0, did_value_reg};
            drvd_pkg::REG_VALUE_BYTES:  prdata = {61'd0, value_bytes_reg};
            drvd_pkg::REG_ENCODING:     prdata = {62'd0, encoding_reg};
            drvd_pkg::REG_SCALE_FACTOR: prdata = {32'd0, scale_factor_reg};
            drvd_pkg::REG_VALUE_OFFSET: prdata = {16'd0, value_offset_reg};
            default:                    prdata = '0;
        endcase
    end

    // ---------------- pipe control ----------------
    logic p1_valid_reg, p2_valid_reg, out_valid_reg;
    logic out_free, p2_free, p1_free;
    logic s_accept;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign p2_free       = !p2_valid_reg || out_free;
    assign p1_free       = !p1_valid_reg || p2_free;
    assign s_axis_tready = p1_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;

    // ---------------- message state ----------------
    logic [2:0]       byte_count_reg, byte_count_next;
    logic             header_match_reg, header_match_next;
    logic [ACC_W-1:0] raw_acc_reg, raw_acc_next;
    logic [1:0]       val_k;
    logic             val_take;

    assign val_k    = 2'(byte_count_reg - drvd_pkg::HDR_LEN);
    assign val_take = (byte_count_reg >= drvd_pkg::HDR_LEN)
                   && (byte_count_reg < drvd_pkg::CNT_MAX)
                   && ({1'b0, val_k} < value_bytes_reg);

    always_comb
    begin
        header_match_next = header_match_reg;
        raw_acc_next      = raw_acc_reg;
        if (byte_count_reg == 3'd0)
        begin
            if (s_axis_tdata != drvd_pkg::RESP_CODE)
                header_match_next = 1'b0;
        end
        else if (byte_count_reg == 3'd1)
        begin
            if (s_axis_tdata != did_value_reg[15:8])
                header_match_next = 1'b0;
        end
        else if (byte_count_reg == 3'd2)
        begin
            if (s_axis_tdata != did_value_reg[7:0])
                header_match_next = 1'b0;
        end
        else if (val_take)
        begin
            if (encoding_reg[1])
            begin
                for (int j = 0; j < MAX_VALUE_BYTES; j++)
                begin
                    if (int'(val_k) == j)
                        raw_acc_next[8*j +: 8] = raw_acc_reg[8*j +: 8] | s_axis_tdata;
                end
            end
            else
            begin
                raw_acc_next = (raw_acc_reg << 8) | ACC_W'(s_axis_tdata);
            end
        end
        byte_count_next = (byte_count_reg < drvd_pkg::CNT_MAX) ? byte_count_reg + 3'd1
                                                                : byte_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            header_match_reg <= 1'b1;
            raw_acc_reg      <= '0;
        end
        else if (s_accept)
        begin
            if (s_axis_tlast)
            begin
                byte_count_reg   <= '0;
                header_match_reg <= 1'b1;
                raw_acc_reg      <= '0;
            end
            else
            begin
                byte_count_reg   <= byte_count_next;
                header_match_reg <= header_match_next;
                raw_acc_reg      <= raw_acc_next;
            end
        end
    end

    // ---------------- final checks, width and sign ----------------
    logic                 cfg_ok;
    drvd_pkg::status_t    status_next;
    logic [ACC_W:0]       rv_bits;
    logic                 rv_sign;

    always_comb
    begin
        if (mapped_reg)
            cfg_ok = (value_bytes_reg >= 3'd1)
                  && (value_bytes_reg <= 3'(MAX_VALUE_BYTES))
                  && (scale_factor_reg != 32'sd0);
        else
            cfg_ok = (value_bytes_reg == 3'd0);

        if (!cfg_ok)
            status_next = drvd_pkg::ST_BAD_CFG;
        else if (!mapped_reg)
            status_next = drvd_pkg::ST_UNMAPPED;
        else if ({1'b0, byte_count_next} < {1'b0, drvd_pkg::HDR_LEN} + {1'b0, value_bytes_reg})
            status_next = drvd_pkg::ST_SHORT;
        else if (!header_match_next)
            status_next = drvd_pkg::ST_UNEXPECTED;
        else
            status_next = drvd_pkg::ST_OK;

        // keep the low value_bytes bytes, sign-extend from the top one if signed
        rv_sign = 1'b0;
        for (int j = 0; j < MAX_VALUE_BYTES; j++)
        begin
            if (j == int'(value_bytes_reg) - 1)
                rv_sign = raw_acc_next[8*j + 7] && encoding_reg[0];
        end
        rv_bits = {rv_sign, {ACC_W{1'b0}}};
        for (int j = 0; j < MAX_VALUE_BYTES; j++)
        begin
            if (j < int'(value_bytes_reg))
                rv_bits[8*j +: 8] = raw_acc_next[8*j +: 8];
            else
                rv_bits[8*j +: 8] = {8{rv_sign}};
        end
        // a failed message carries zeros so the result comes out as zero
        if (status_next != drvd_pkg::ST_OK)
            rv_bits = '0;
    end

    // stage 1 registers
    drvd_pkg::status_t  p1_status_reg;
    logic signed [ACC_W:0] p1_rv_reg;
    logic signed [31:0] p1_scale_reg;
    logic signed [47:0] p1_offset_reg;

    // stage 2 registers
    drvd_pkg::status_t  p2_status_reg;
    logic signed [63:0] p2_prod_reg;
    logic signed [47:0] p2_offset_reg;

    // output registers
    drvd_pkg::status_t  out_status_reg;
    logic [63:0]        out_value_reg;

    logic signed [ACC_W+32:0] mul_full;
    logic signed [64:0]       sum_full;
    logic [63:0]              sat_value;

    assign mul_full = p1_rv_reg * p1_scale_reg;
    assign sum_full = 65'(p2_prod_reg) + 65'(p2_offset_reg);

    always_comb
    begin
        case (sum_full[64:63])
            2'b01:   sat_value = drvd_pkg::SAT_POS;
            2'b10:   sat_value = drvd_pkg::SAT_NEG;
            default: sat_value = sum_full[63:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_free)
                p1_valid_reg <= s_accept && s_axis_tlast;
            if (p2_free)
                p2_valid_reg <= p1_valid_reg;
            if (out_free)
                out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_free && s_accept && s_axis_tlast)
        begin
            p1_status_reg <= status_next;
            p1_rv_reg     <= rv_bits;
            p1_scale_reg  <= scale_factor_reg;
            p1_offset_reg <= (status_next == drvd_pkg::ST_OK) ? value_offset_reg : 48'sd0;
        end
        if (p2_free && p1_valid_reg)
        begin
            p2_status_reg <= p1_status_reg;
            p2_prod_reg   <= 64'(mul_full);
            p2_offset_reg <= p1_offset_reg;
        end
        if (out_free && p2_valid_reg)
        begin
            out_status_reg <= p2_status_reg;
            out_value_reg  <= sat_value;
        end
    end

    assign m_axis_tdata = {5'd0, out_value_reg, out_status_reg};

    // ---------------- assertions ----------------
    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && !s_axis_tlast && byte_count_reg != drvd_pkg::CNT_MAX
        |=> byte_count_reg == $past(byte_count_reg) + 3'd1)
        else $error("byte count did not advance on a taken byte");

    a_msg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_axis_tlast |=> byte_count_reg == 3'd0 && header_match_reg)
        else $error("message state not cleared after last byte");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg && p1_status_reg != drvd_pkg::ST_OK
        |-> p1_rv_reg == 0 && p1_offset_reg == 0)
        else $error("failed message carries nonzero operands");

    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != drvd_pkg::ST_OK |-> out_value_reg == 64'd0)
        else $error("nonzero value with failing status");

endmodule

@@ verif/did_response_value_decoder_top_tb.sv @@
// Self-checking testbench for the data-identifier response value decoder.
`timescale 1ns / 1ps

module did_response_value_decoder_top_tb;

    localparam int MAX_VALUE_BYTES = 4;
    localparam int DIR_ROWS        = 9;
    localparam int RAND_BYTES      = 500;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int STALL_CYCLES    = 300;

    typedef struct packed {
        logic        mapped;
        logic [15:0] did;
        logic [2:0]  vbytes;
        logic [1:0]  enc;
        logic [31:0] scale;
        logic [47:0] offset;
    } dec_cfg_t;

    typedef struct packed {
        drvd_pkg::status_t st;
        logic [63:0]       val;
    } decoded_t;

    typedef struct {
        bit                do_cfg;
        dec_cfg_t          cfg;
        int                nbytes;
        logic [63:0]       msg;       // byte 0 in the low bits
        bit                typed;
        drvd_pkg::status_t st;
        logic [63:0]       val;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    // predictor copy of the registers and of the message state
    dec_cfg_t    cur_cfg = '0;
    logic [2:0]  msg_count = '0;
    logic        hdr_ok = 1'b1;
    logic [31:0] raw_acc = '0;

    decoded_t    decoded_q[$];
    dir_row_t    dir_rows[DIR_ROWS];
    bit          use_typed = 1'b0;
    decoded_t    typed_word;

    bit          calm = 1'b0;
    bit          stall_req = 1'b0;
    bit          stall_used = 1'b0;
    int          stall_left = 0;
    int          cycles = 0;
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          rand_bytes = 0;
    int          n_settings = 0;
    int          n_results = 0;
    int          n_saturated = 0;
    int          status_seen[5];

    always #1 clk = ~clk;

    did_response_value_decoder_top #(
        .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, what);
    endtask

    // Advances the message state by one byte; returns 1 when the byte closes
    // the message, with the decoded status and value.
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output drvd_pkg::status_t st,
                                       output logic [63:0] val);
        logic [2:0]         k;
        logic [63:0]        mask;
        logic [63:0]        raw;
        logic signed [63:0] prod;
        logic [64:0]        sum;
        bit                 cfg_ok;
        st  = drvd_pkg::ST_OK;
        val = '0;
        case (msg_count)
            3'd0: if (b != drvd_pkg::RESP_CODE) hdr_ok = 1'b0;
            3'd1: if (b != cur_cfg.did[15:8]) hdr_ok = 1'b0;
            3'd2: if (b != cur_cfg.did[7:0]) hdr_ok = 1'b0;
            default:
            begin
                k = msg_count - drvd_pkg::HDR_LEN;
                if (msg_count < drvd_pkg::CNT_MAX && k < cur_cfg.vbytes)
                begin
                    if (cur_cfg.enc[1])
                        raw_acc = raw_acc | ({24'd0, b} << (8 * k));
                    else
                        raw_acc = {raw_acc[23:0], b};
                end
            end
        endcase
        if (msg_count < drvd_pkg::CNT_MAX)
            msg_count = msg_count + 3'd1;
        if (!last)
            return 1'b0;

        cfg_ok = cur_cfg.mapped ? (cur_cfg.vbytes >= 3'd1 && cur_cfg.vbytes <= MAX_VALUE_BYTES
                                   && cur_cfg.scale != '0)
                                : (cur_cfg.vbytes == 3'd0);
        if (!cfg_ok)
            st = drvd_pkg::ST_BAD_CFG;
        else if (!cur_cfg.mapped)
            st = drvd_pkg::ST_UNMAPPED;
        else if (int'(msg_count) < int'(drvd_pkg::HDR_LEN) + int'(cur_cfg.vbytes))
            st = drvd_pkg::ST_SHORT;
        else if (!hdr_ok)
            st = drvd_pkg::ST_UNEXPECTED;
        else
        begin
            mask = (64'd1 << (8 * cur_cfg.vbytes)) - 64'd1;
            raw  = {32'd0, raw_acc} & mask;
            if (cur_cfg.enc[0] && raw[8 * cur_cfg.vbytes - 1])
                raw = raw | ~mask;
            prod = $signed(raw) * $signed({{32{cur_cfg.scale[31]}}, cur_cfg.scale});
            sum  = {prod[63], prod} + {{17{cur_cfg.offset[47]}}, cur_cfg.offset};
            if (sum[64] != sum[63])
                val = sum[64] ? drvd_pkg::SAT_NEG : drvd_pkg::SAT_POS;
            else
                val = sum[63:0];
        end
        msg_count = '0;
        hdr_ok    = 1'b1;
        raw_acc   = '0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h80;
            3:       return 8'h7f;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic dec_cfg_t rand_config();
        dec_cfg_t    c;
        logic [63:0] r64;
        int          sel;
        sel = $urandom_range(9);
        r64 = {$urandom, $urandom};
        case ($urandom_range(5))
            0:       c.did = 16'h0000;
            1:       c.did = 16'hffff;
            default: c.did = 16'($urandom_range(16'hffff));
        endcase
        c.enc = 2'($urandom_range(3));
        case ($urandom_range(7))
            0:       c.scale = 32'h7fff_ffff;
            1:       c.scale = 32'h8000_0000;
            2:       c.scale = 32'h0001_0000;
            3:       c.scale = 32'hffff_ffff;
            default: c.scale = $urandom;
        endcase
        case ($urandom_range(5))
            0:       c.offset = 48'h7fff_ffff_ffff;
            1:       c.offset = 48'h8000_0000_0000;
            2:       c.offset = '0;
            default: c.offset = r64[47:0];
        endcase
        if (sel == 0)
        begin
            c.mapped = 1'b0;
            c.vbytes = 3'd0;
        end
        else if (sel == 1)
        begin
            // one of the ways a setting can be rejected
            case ($urandom_range(3))
                0:
                begin
                    c.mapped = 1'b1;
                    c.vbytes = 3'($urandom_range(7, 5));
                end
                1:
                begin
                    c.mapped = 1'b0;
                    c.vbytes = 3'($urandom_range(7, 1));
                end
                2:
                begin
                    c.mapped = 1'b1;
                    c.vbytes = 3'($urandom_range(4, 1));
                    c.scale  = '0;
                end
                default:
                begin
                    c.mapped = 1'b1;
                    c.vbytes = 3'd0;
                end
            endcase
        end
        else
        begin
            c.mapped = 1'b1;
            c.vbytes = 3'($urandom_range(4, 1));
            if (c.scale == '0)
                c.scale = 32'd1;
        end
        return c;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Drops s_axis_tvalid and lets every awaited word arrive before returning.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input dec_cfg_t c);
        wait_drained();
        reg_write(drvd_pkg::REG_MAPPED,       {63'd0, c.mapped});
        reg_write(drvd_pkg::REG_DID_VALUE,    {48'd0, c.did});
        reg_write(drvd_pkg::REG_VALUE_BYTES,  {61'd0, c.vbytes});
        reg_write(drvd_pkg::REG_ENCODING,     {62'd0, c.enc});
        reg_write(drvd_pkg::REG_SCALE_FACTOR, {32'd0, c.scale});
        reg_write(drvd_pkg::REG_VALUE_OFFSET, {16'd0, c.offset});
        cur_cfg = c;
        n_settings++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        drvd_pkg::status_t st;
        logic [63:0]       v;
        decoded_t          w;
        if (!calm && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(255));
            s_axis_tlast  <= 1'($urandom_range(1));
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
        if (decode_byte(b, last, st, v))
        begin
            if (use_typed)
                w = typed_word;
            else
            begin
                w.st  = st;
                w.val = v;
            end
            decoded_q.push_back(w);
        end
    endtask

    task automatic send_random_message();
        logic [7:0] msg[$];
        int         kind;
        int         nval;
        int         extra;
        int         cut;
        int         pos;
        kind  = $urandom_range(99);
        extra = 0;
        if (kind < 86)
        begin
            nval = (cur_cfg.vbytes >= 3'd1 && cur_cfg.vbytes <= 3'd4) ? int'(cur_cfg.vbytes)
                                                                     : $urandom_range(4, 1);
            msg.push_back(drvd_pkg::RESP_CODE);
            msg.push_back(cur_cfg.did[15:8]);
            msg.push_back(cur_cfg.did[7:0]);
            repeat (nval) msg.push_back(pick_byte());
            if ($urandom_range(4) == 0)
                extra = $urandom_range(3, 1);
            repeat (extra) msg.push_back(pick_byte());
            if (kind >= 60 && kind < 72)
            begin
                // cut short somewhere before the end
                cut = $urandom_range(msg.size() - 1, 1);
                while (msg.size() > cut)
                    void'(msg.pop_back());
                extra = 0;
            end
            else if (kind >= 72)
            begin
                pos = $urandom_range(2);
                msg[pos] = msg[pos] ^ 8'($urandom_range(255, 1));
            end
        end
        else
        begin
            repeat ($urandom_range(10, 1)) msg.push_back(pick_byte());
        end
        for (int i = 0; i < msg.size(); i++)
            send_byte(msg[i], i == msg.size() - 1);
        rand_bytes += msg.size();
    endtask

    // result side: ready pattern, long hold-off on request, word check
    always @(posedge clk)
    begin : result_side
        decoded_t    want;
        logic [2:0]  got_st;
        logic [63:0] got_val;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_st  = m_axis_tdata[2:0];
                got_val = m_axis_tdata[66:3];
                if (decoded_q.size() == 0)
                    flag_mismatch($sformatf("result word with nothing awaited: status %0d value %h",
                                            got_st, got_val));
                else
                begin
                    want = decoded_q.pop_front();
                    n_results++;
                    status_seen[want.st]++;
                    if (want.st == drvd_pkg::ST_OK
                        && (want.val == drvd_pkg::SAT_POS || want.val == drvd_pkg::SAT_NEG))
                        n_saturated++;
                    if (got_st !== want.st || got_val !== want.val)
                        flag_mismatch($sformatf("status exp %0d got %0d, value exp %h got %h",
                                                want.st, got_st, want.val, got_val));
                end
            end
            if (stall_req && !stall_used)
            begin
                stall_used = 1'b1;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (calm)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 26);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int phase;
        dir_rows[0] = '{1'b0, '{1'b0, 16'h0000, 3'd0, 2'd0, 32'h0, 48'h0},
                        1, 64'h62, 1'b1, drvd_pkg::ST_UNMAPPED, 64'h0};
        // value length too large, length while unmapped, zero factor
        dir_rows[1] = '{1'b1, '{1'b1, 16'h1234, 3'd7, 2'd0, 32'h1, 48'h0},
                        1, 64'h62, 1'b1, drvd_pkg::ST_BAD_CFG, 64'h0};
        dir_rows[2] = '{1'b1, '{1'b0, 16'h1234, 3'd2, 2'd0, 32'h1, 48'h0},
                        1, 64'h00, 1'b1, drvd_pkg::ST_BAD_CFG, 64'h0};
        dir_rows[3] = '{1'b1, '{1'b1, 16'h1234, 3'd2, 2'd0, 32'h0, 48'h0},
                        1, 64'hff, 1'b1, drvd_pkg::ST_BAD_CFG, 64'h0};
        dir_rows[4] = '{1'b1, '{1'b1, 16'hffff, 3'd4, 2'd1, 32'h1, 48'h0},
                        2, 64'hff62, 1'b1, drvd_pkg::ST_SHORT, 64'h0};
        dir_rows[5] = '{1'b1, '{1'b1, 16'hffff, 3'd1, 2'd0, 32'h1, 48'h0},
                        4, 64'h00fe_ff62, 1'b1, drvd_pkg::ST_UNEXPECTED, 64'h0};
        // largest and most negative products pushed past the 64-bit range
        dir_rows[6] = '{1'b1, '{1'b1, 16'h1234, 3'd4, 2'd0, 32'h7fff_ffff, 48'h7fff_ffff_ffff},
                        7, 64'h00ff_ffff_ff34_1262, 1'b1, drvd_pkg::ST_OK, drvd_pkg::SAT_POS};
        dir_rows[7] = '{1'b1, '{1'b1, 16'h1234, 3'd4, 2'd0, 32'h8000_0000, 48'h8000_0000_0000},
                        7, 64'h00ff_ffff_ff34_1262, 1'b1, drvd_pkg::ST_OK, drvd_pkg::SAT_NEG};
        // signed little endian with a trailing byte that is ignored
        dir_rows[8] = '{1'b1, '{1'b1, 16'h1234, 3'd1, 2'd3, 32'h0001_0000, 48'h1},
                        5, 64'h55_fe34_1262, 1'b0, drvd_pkg::ST_OK, 64'h0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].do_cfg)
                apply_config(dir_rows[r].cfg);
            use_typed      = dir_rows[r].typed;
            typed_word.st  = dir_rows[r].st;
            typed_word.val = dir_rows[r].val;
            for (int i = 0; i < dir_rows[r].nbytes; i++)
                send_byte(dir_rows[r].msg[8 * i +: 8], i == dir_rows[r].nbytes - 1);
        end
        use_typed = 1'b0;

        phase = 0;
        while (rand_bytes < RAND_BYTES)
        begin
            apply_config(rand_config());
            calm <= (phase == 3);
            if (phase == 5)
                stall_req <= 1'b1;
            repeat ($urandom_range(10, 4)) send_random_message();
            phase++;
        end
        calm <= 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        $display("decoded %0d responses from %0d bytes under %0d register settings, %0d saturated",
                 n_results, bytes_sent, n_settings, n_saturated);
        $display("status mix: ok %0d, bad config %0d, unmapped %0d, too short %0d, bad header %0d",
                 status_seen[drvd_pkg::ST_OK], status_seen[drvd_pkg::ST_BAD_CFG],
                 status_seen[drvd_pkg::ST_UNMAPPED], status_seen[drvd_pkg::ST_SHORT],
                 status_seen[drvd_pkg::ST_UNEXPECTED]);
        if (mismatches == 0 && decoded_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
